/* rtl/core/idrg_pkg.sv */
// Shared types, constants and helpers for the inertial guidance block.
// No dependencies; imported by the guidance top level, its multiplier and checker.
package idrg_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // serial multiplier operand magnitudes
  localparam int MAW = 40;
  localparam int MBW = 32;

  // CORDIC vector and angle widths (angles in signed Q5.30)
  localparam int XW = 60;
  localparam int ZW = 35;

  localparam logic signed [ZW-1:0] PI_Z      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Z = 35'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Z  = 35'sd6746518852;
  localparam longint               TWO_PI_L  = 64'sd6746518852;
  localparam logic signed [XW-1:0] INV_K_X   = 60'sd652032874;
  localparam logic [31:0]          INV_K_Q26 = 32'd40752055;
  localparam int                   VEC_SHIFT = 24;

  typedef enum logic [2:0] {
    CFG_GOAL_X, CFG_GOAL_Y, CFG_GAIN_P, CFG_GAIN_I,
    CFG_GAIN_D, CFG_GAIN_DIST, CFG_SAMPLE_PERIOD, CFG_STOP_RADIUS
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] gyro_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] turn_rate;
    logic signed [31:0] cmd_vel_x;
    logic signed [31:0] cmd_vel_y;
    logic               arrived;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic rnd_hi;   // round at bit 30 instead of the value fraction
  } mul_ctl_t;

  // atan(2^-i) in Q30, rounded
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd31: r = 30'd1;
      default: r = 30'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    logic signed [79:0] smax;
    logic signed [79:0] smin;
    smax = 80'sh7FFFFFFF;
    smin = -smax - 80'sd1;
    if (v > smax) return 32'sh7FFFFFFF;
    if (v < smin) return 32'sh80000000;
    return 32'(v);
  endfunction

endpackage

/* rtl/core/idrg_smul.sv */
// Bit-serial signed multiplier with rounding: one multiplier bit per cycle.
// Depends on idrg_pkg (operand widths, control struct).
module idrg_smul #(
  parameter int FRAC_BITS = idrg_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  idrg_pkg::mul_ctl_t      ctl,
  input  logic signed [idrg_pkg::MAW:0] a,
  input  logic signed [idrg_pkg::MBW:0] b,
  output logic                    done,
  output logic signed [idrg_pkg::MAW+idrg_pkg::MBW+1-FRAC_BITS:0] res
);
  import idrg_pkg::*;

  localparam int PW = MAW + MBW + 1;
  localparam int RW = PW - FRAC_BITS + 1;
  localparam int CW = $clog2(MBW);

  logic [MAW-1:0]   ma_r;
  logic [PW-1:0]    p_r;
  logic             neg_r, sel_r, run_r, fin_r, done_r;
  logic [CW-1:0]    cnt_r;
  logic signed [RW-1:0] res_r;

  logic [MAW:0]     sum;
  logic [PW-1:0]    pr;
  logic [RW-2:0]    mag;

  // partial product added into the upper half, multiplier shifts out below
  assign sum = p_r[PW-1:MBW] + (p_r[0] ? {1'b0, ma_r} : '0);
  assign pr  = p_r + (sel_r ? (PW'(1) << 29) : (PW'(1) << (FRAC_BITS - 1)));
  assign mag = sel_r ? (RW-1)'(pr >> 30) : (RW-1)'(pr >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        ma_r  <= MAW'(a[MAW] ? -a : a);
        p_r   <= {(MAW+1)'(0), MBW'(b[MBW] ? -b : b)};
        neg_r <= a[MAW] ^ b[MBW];
        sel_r <= ctl.rnd_hi;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        p_r   <= {1'b0, sum, p_r[MBW-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(MBW - 1)) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        res_r  <= neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        done_r <= 1'b1;
        fin_r  <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

/* rtl/core/imu_dead_reckon_pid_guidance.sv */
// Guidance top level: dead reckoning, CORDIC trig/bearing/distance, PID and speed law.
// Depends on idrg_pkg and idrg_smul.
// Each word's time is set by the bit-serial multiplier passes; the first word after reset
// skips the heading and dead-reckoning passes.
// One word at a time; after arrival a word goes straight from idle to the result stage.
// Reset (synchronous, rst_n low) restores registers and pose; no clearing pass.
module imu_dead_reckon_pid_guidance #(
  parameter int FRAC_BITS    = idrg_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = idrg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  idrg_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output idrg_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [31:0]         cfg_wdata
);
  import idrg_pkg::*;

  localparam int AS   = 30 - FRAC_BITS;
  localparam int KMAX = 29 - FRAC_BITS;
  localparam int ZMW  = 32 + AS;
  localparam int RW   = MAW + MBW + 2 - FRAC_BITS;
  localparam int IW   = $clog2(CORDIC_STEPS);

  localparam longint BIAS_G  = ((longint'(100) << FRAC_BITS) + 5000) / 10000;
  localparam longint BIAS_AX = ((longint'(337) << FRAC_BITS) + 5000) / 10000;
  localparam longint BIAS_AY = ((longint'(7182) << FRAC_BITS) + 5000) / 10000;
  localparam longint GOAL_RST = longint'(10) << FRAC_BITS;
  localparam longint TENTH    = ((longint'(1) << FRAC_BITS) + 5) / 10;
  localparam longint SP_RST   = ((longint'(2) << FRAC_BITS) + 50) / 100;
  localparam longint ONE      = longint'(1) << FRAC_BITS;
  localparam longint HEAD_RST = ((longint'(15707963) << FRAC_BITS) + 5000000) / 10000000;
  localparam logic [ZMW-1:0]       TWOPI_TOP = ZMW'(TWO_PI_L << KMAX);
  localparam logic signed [XW-1:0] RND_X = XW'(longint'(1) << (AS - 1));
  localparam logic signed [ZW-1:0] RND_Z = ZW'(longint'(1) << (AS - 1));

  typedef enum logic [4:0] {
    S_IDLE, S_HEAD, S_RINIT, S_RED, S_RFIX, S_CRD, S_SC,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
    S_VINIT, S_VFIN, S_DIST, S_PID0, S_P1, S_P2, S_P3,
    S_V, S_C1, S_C2, S_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic signed [31:0] goal_x_r, goal_y_r;
  logic [30:0] gain_p_r, gain_i_r, gain_d_r, gain_dist_r, period_r, stop_r;

  // pose and controller state
  logic signed [31:0] heading_r, pos_x_r, pos_y_r, vel_x_r, vel_y_r, esum_r, prev_r;
  logic               started_r, done_r;

  // per-word working registers
  logic signed [31:0] rate_r, ax_r, ay_r, c_r, s_r, wx_r, wy_r, err_r, w_r, v_r;
  logic signed [31:0] bearing_r;
  logic signed [32:0] derr_r;
  logic [31:0]        dist_r;
  logic signed [RW:0] tmp_r;
  logic               pend_r;

  // angle reduction and CORDIC
  logic [ZMW-1:0]     zm_r, twopi_r;
  logic               zneg_r, flip_r, vec_r;
  logic [4:0]         red_cnt_r;
  logic signed [XW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic [IW-1:0]      it_r;

  logic               out_valid_r;
  out_word_t          out_word_r;

  // multiplier
  mul_ctl_t           mctl;
  logic signed [MAW:0] ma;
  logic signed [MBW:0] mb;
  logic               mdone;
  logic signed [RW-1:0] mres;
  logic               is_mul;

  idrg_smul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mctl),
    .a    (ma),
    .b    (mb),
    .done (mdone),
    .res  (mres)
  );

  always_comb begin
    is_mul = 1'b1;
    ma = 41'(rate_r);
    mb = $signed({2'b00, period_r});
    mctl.rnd_hi = 1'b0;
    case (state_r)
      S_HEAD: ma = 41'(rate_r);
      S_M1:   begin ma = 41'(ax_r); mb = 33'(c_r); end
      S_M2:   begin ma = 41'(ay_r); mb = 33'(s_r); end
      S_M3:   begin ma = 41'(ax_r); mb = 33'(s_r); end
      S_M4:   begin ma = 41'(ay_r); mb = 33'(c_r); end
      S_M5:   ma = 41'(wx_r);
      S_M6:   ma = 41'(wy_r);
      S_M7:   ma = 41'(vel_x_r);
      S_M8:   ma = 41'(vel_y_r);
      S_DIST: begin
        ma = 41'(cx_r >>> 20);
        mb = $signed({1'b0, INV_K_Q26});
        mctl.rnd_hi = 1'b1;
      end
      S_P1:   begin ma = 41'(esum_r); mb = $signed({2'b00, gain_i_r}); end
      S_P2:   begin ma = 41'(derr_r); mb = $signed({2'b00, gain_d_r}); end
      S_P3:   begin ma = 41'(err_r);  mb = $signed({2'b00, gain_p_r}); end
      S_V:    begin ma = $signed({9'd0, dist_r}); mb = $signed({2'b00, gain_dist_r}); end
      S_C1:   begin ma = 41'(v_r); mb = 33'(c_r); end
      S_C2:   begin ma = 41'(v_r); mb = 33'(s_r); end
      default: is_mul = 1'b0;
    endcase
    mctl.start = is_mul && !pend_r;
  end

  // CORDIC micro-rotation, shared by rotation and vectoring
  logic                 dplus;
  logic signed [XW-1:0] xs, ys, cx_nxt, cy_nxt;
  logic signed [ZW-1:0] at_s, cz_nxt;

  assign dplus = vec_r ? cy_r[XW-1] : !cz_r[ZW-1];
  assign xs    = cx_r >>> it_r;
  assign ys    = cy_r >>> it_r;
  assign at_s  = $signed({{(ZW-30){1'b0}}, atan_q30(5'(it_r))});

  always_comb begin
    if (dplus) begin
      cx_nxt = cx_r - ys;
      cy_nxt = cy_r + xs;
      cz_nxt = cz_r - at_s;
    end else begin
      cx_nxt = cx_r + ys;
      cy_nxt = cy_r - xs;
      cz_nxt = cz_r + at_s;
    end
  end

  // fold reduced angle into [-pi/2, pi/2]
  logic signed [ZW-1:0] zr, z1, zf;
  logic                 zflip;
  always_comb begin
    zr = zneg_r ? -$signed(ZW'(zm_r)) : $signed(ZW'(zm_r));
    if (zr > PI_Z) z1 = zr - TWO_PI_Z;
    else if (zr < -PI_Z) z1 = zr + TWO_PI_Z;
    else z1 = zr;
    zflip = 1'b1;
    if (z1 > HALF_PI_Z) zf = z1 - PI_Z;
    else if (z1 < -HALF_PI_Z) zf = z1 + PI_Z;
    else begin
      zf = z1;
      zflip = 1'b0;
    end
  end

  logic [31:0]          habs;
  logic signed [XW-1:0] xf, yf, dx0, dy0;
  logic signed [32:0]   dx, dy;
  logic signed [31:0]   err_nxt;
  logic                 arrive;

  assign habs    = heading_r[31] ? 32'(-heading_r) : 32'(heading_r);
  assign xf      = flip_r ? -cx_r : cx_r;
  assign yf      = flip_r ? -cy_r : cy_r;
  assign dx      = 33'(goal_x_r) - 33'(pos_x_r);
  assign dy      = 33'(goal_y_r) - 33'(pos_y_r);
  assign dx0     = XW'(dx) <<< VEC_SHIFT;
  assign dy0     = XW'(dy) <<< VEC_SHIFT;
  assign err_nxt = sat32(80'(heading_r) - 80'(bearing_r));
  assign arrive  = done_r || (dist_r < {1'b0, stop_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      done_r      <= 1'b0;
      heading_r   <= 32'(HEAD_RST);
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      vel_x_r     <= '0;
      vel_y_r     <= '0;
      esum_r      <= '0;
      prev_r      <= '0;
      goal_x_r    <= 32'(GOAL_RST);
      goal_y_r    <= 32'(GOAL_RST);
      gain_p_r    <= 31'(GOAL_RST);
      gain_i_r    <= 31'(TENTH);
      gain_d_r    <= 31'(TENTH);
      gain_dist_r <= 31'(TENTH);
      period_r    <= 31'(SP_RST);
      stop_r      <= 31'(ONE);
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_GOAL_X:        goal_x_r    <= cfg_wdata;
          CFG_GOAL_Y:        goal_y_r    <= cfg_wdata;
          CFG_GAIN_P:        gain_p_r    <= cfg_wdata[30:0];
          CFG_GAIN_I:        gain_i_r    <= cfg_wdata[30:0];
          CFG_GAIN_D:        gain_d_r    <= cfg_wdata[30:0];
          CFG_GAIN_DIST:     gain_dist_r <= cfg_wdata[30:0];
          CFG_SAMPLE_PERIOD: period_r    <= cfg_wdata[30:0];
          CFG_STOP_RADIUS:   stop_r      <= cfg_wdata[30:0];
          default: ;
        endcase
      end

      // S_FIN reloads the result register itself
      if (out_valid_r && !out_stall && state_r != S_FIN) out_valid_r <= 1'b0;

      if (is_mul) begin
        if (!pend_r) pend_r <= 1'b1;
        else if (mdone) pend_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            rate_r <= sat32(80'(in_word.gyro_z) - 80'(BIAS_G));
            ax_r   <= sat32(80'(in_word.accel_x) - 80'(BIAS_AX));
            ay_r   <= sat32(80'(in_word.accel_y) - 80'(BIAS_AY));
            if (done_r) state_r <= S_FIN;
            else if (started_r) state_r <= S_HEAD;
            else state_r <= S_RINIT;
          end
        end
        S_HEAD: if (pend_r && mdone) begin
          heading_r <= sat32(80'(heading_r) + 80'(mres));
          state_r   <= S_RINIT;
        end
        S_RINIT: begin
          zm_r      <= {ZMW'(habs)} << AS;
          zneg_r    <= heading_r[31];
          twopi_r   <= TWOPI_TOP;
          red_cnt_r <= 5'(KMAX);
          state_r   <= S_RED;
        end
        S_RED: begin
          // restoring reduction by 2*pi, one quotient bit per cycle
          if (zm_r >= twopi_r) zm_r <= zm_r - twopi_r;
          twopi_r   <= twopi_r >> 1;
          red_cnt_r <= red_cnt_r - 1'b1;
          if (red_cnt_r == '0) state_r <= S_RFIX;
        end
        S_RFIX: begin
          cx_r    <= INV_K_X;
          cy_r    <= '0;
          cz_r    <= zf;
          flip_r  <= zflip;
          vec_r   <= 1'b0;
          it_r    <= '0;
          state_r <= S_CRD;
        end
        S_CRD: begin
          cx_r <= cx_nxt;
          cy_r <= cy_nxt;
          cz_r <= cz_nxt;
          it_r <= it_r + 1'b1;
          if (it_r == IW'(CORDIC_STEPS - 1)) state_r <= vec_r ? S_VFIN : S_SC;
        end
        S_SC: begin
          c_r     <= 32'((xf + RND_X) >>> AS);
          s_r     <= 32'((yf + RND_X) >>> AS);
          state_r <= started_r ? S_M1 : S_VINIT;
        end
        S_M1: if (pend_r && mdone) begin
          tmp_r <= (RW+1)'(mres);
          state_r <= S_M2;
        end
        S_M2: if (pend_r && mdone) begin
          wx_r <= sat32(80'(tmp_r) - 80'(mres));
          state_r <= S_M3;
        end
        S_M3: if (pend_r && mdone) begin
          tmp_r <= (RW+1)'(mres);
          state_r <= S_M4;
        end
        S_M4: if (pend_r && mdone) begin
          wy_r <= sat32(80'(tmp_r) + 80'(mres));
          state_r <= S_M5;
        end
        S_M5: if (pend_r && mdone) begin
          vel_x_r <= sat32(80'(vel_x_r) + 80'(mres));
          state_r <= S_M6;
        end
        S_M6: if (pend_r && mdone) begin
          vel_y_r <= sat32(80'(vel_y_r) + 80'(mres));
          state_r <= S_M7;
        end
        S_M7: if (pend_r && mdone) begin
          pos_x_r <= sat32(80'(pos_x_r) + 80'(mres));
          state_r <= S_M8;
        end
        S_M8: if (pend_r && mdone) begin
          pos_y_r <= sat32(80'(pos_y_r) + 80'(mres));
          state_r <= S_VINIT;
        end
        S_VINIT: begin
          vec_r <= 1'b1;
          it_r  <= '0;
          if (dx == '0 && dy == '0) begin
            bearing_r <= '0;
            dist_r    <= '0;
            state_r   <= S_PID0;
          end else begin
            cx_r    <= dx[32] ? -dx0 : dx0;
            cy_r    <= dx[32] ? -dy0 : dy0;
            cz_r    <= dx[32] ? (dy[32] ? -PI_Z : PI_Z) : '0;
            state_r <= S_CRD;
          end
        end
        S_VFIN: begin
          bearing_r <= 32'((cz_r + RND_Z) >>> AS);
          state_r   <= S_DIST;
        end
        S_DIST: if (pend_r && mdone) begin
          // distance saturates before the speed gain
          if (80'(mres) > 80'sh7FFFFFFF) dist_r <= 32'h7FFFFFFF;
          else dist_r <= 32'(mres);
          state_r <= S_PID0;
        end
        S_PID0: begin
          err_r   <= err_nxt;
          esum_r  <= sat32(80'(esum_r) + 80'(err_nxt));
          derr_r  <= 33'(err_nxt) - 33'(prev_r);
          state_r <= S_P1;
        end
        S_P1: if (pend_r && mdone) begin
          tmp_r <= (RW+1)'(mres);
          state_r <= S_P2;
        end
        S_P2: if (pend_r && mdone) begin
          tmp_r <= tmp_r + (RW+1)'(mres);
          state_r <= S_P3;
        end
        S_P3: if (pend_r && mdone) begin
          w_r     <= sat32(80'(tmp_r) - 80'(mres));
          prev_r  <= err_r;
          state_r <= S_V;
        end
        S_V: if (pend_r && mdone) begin
          v_r <= sat32(80'(mres));
          state_r <= S_C1;
        end
        S_C1: if (pend_r && mdone) begin
          vel_x_r <= sat32(80'(mres));
          state_r <= S_C2;
        end
        S_C2: if (pend_r && mdone) begin
          vel_y_r <= sat32(80'(mres));
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            started_r   <= 1'b1;
            if (arrive) begin
              vel_x_r    <= '0;
              vel_y_r    <= '0;
              done_r     <= 1'b1;
              out_word_r <= '{turn_rate: '0, cmd_vel_x: '0, cmd_vel_y: '0, arrived: 1'b1};
            end else begin
              out_word_r <= '{turn_rate: w_r, cmd_vel_x: vel_x_r, cmd_vel_y: vel_y_r,
                              arrived: 1'b0};
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* rtl/core/idrg_chk.sv */
// Port-level checker for the guidance block, attached by bind.
// Depends on idrg_pkg (word types).
module idrg_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input idrg_pkg::out_word_t out_word
);
  import idrg_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // arrival words carry zero commands
  a_arrived_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.arrived |->
      out_word.turn_rate == '0 && out_word.cmd_vel_x == '0 && out_word.cmd_vel_y == '0)
    else $error("arrival word with nonzero command");

  // one word in flight: accepting makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind imu_dead_reckon_pid_guidance idrg_chk u_idrg_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);

/* tb/imu_dead_reckon_pid_guidance_tb.sv */
// Self-checking testbench for imu_dead_reckon_pid_guidance: random and directed IMU words,
// checked against a bit-exact dead-reckoning/PID predictor. Depends on idrg_pkg and the RTL.
module imu_dead_reckon_pid_guidance_tb;
  import idrg_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;
  localparam longint PI_A        = 64'sd3373259426;
  localparam longint HALF_PI_A   = 64'sd1686629713;
  localparam longint TWO_PI_A    = 64'sd6746518852;
  localparam longint INV_GAIN    = 64'sd652032874;
  localparam longint INV_GAIN_26 = 64'sd40752055;
  localparam longint GYRO_BIAS   = 64'sd655;
  localparam longint ACCX_BIAS   = 64'sd2209;
  localparam longint ACCY_BIAS   = 64'sd47068;
  localparam longint HDG_RESET   = 64'sd102944;
  localparam longint ONE         = 64'sd65536;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  imu_dead_reckon_pid_guidance uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // predictor state and register copies
  longint goal_x_r, goal_y_r, kp, ki, kd, kdist, dt, radius;
  longint hdg, px, py, vx, vy, err_sum, err_prev;
  bit     begun, landed;
  longint atan_tab [0:31];

  out_word_t   cmd_q [$];
  int          mismatches = 0;
  longint      cycles = 0;
  logic [31:0] next_regs [8];
  int          stall_left = 0;
  bit          hold_req = 1'b0;
  bit          quiet = 1'b0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sext32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // product rounded to nearest, ties away from zero
  function automatic longint fxmul(longint a, longint b);
    bit neg;
    longint unsigned ua, ub, p;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? longint'(-a) : a;
    ub = (b < 0) ? longint'(-b) : b;
    p = (ua * ub + 64'd32768) >> 16;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  task automatic build_atan();
    longint acc, term;
    int e;
    atan_tab[0] = 64'sd843314857;
    for (int i = 1; i < 32; i++) begin
      acc = 0;
      for (int k = 0; ; k++) begin
        e = i * (2 * k + 1);
        if (e > 60) break;
        term = (64'sd1 <<< (60 - e)) / longint'(2 * k + 1);
        acc = (k % 2) ? acc - term : acc + term;
      end
      atan_tab[i] = (acc + (64'sd1 <<< 29)) >>> 30;
    end
  endtask

  task automatic rotate_unit(input longint ang, output longint c, output longint s);
    longint z, x, y, t;
    bit flip;
    z = (ang * 64'sd16384) % TWO_PI_A;
    x = INV_GAIN;
    y = 0;
    flip = 1'b0;
    if (z > PI_A) z -= TWO_PI_A;
    if (z < -PI_A) z += TWO_PI_A;
    if (z > HALF_PI_A) begin
      z -= PI_A;
      flip = 1'b1;
    end else if (z < -HALF_PI_A) begin
      z += PI_A;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = round_shr(x, 14);
    s = round_shr(y, 14);
  endtask

  task automatic bearing_range(input longint dx, input longint dy,
                               output longint brg, output longint rng);
    longint x, y, z, t;
    longint unsigned ux;
    x = dx * 64'sd16777216;
    y = dy * 64'sd16777216;
    z = 0;
    if (dx == 0 && dy == 0) begin
      brg = 0;
      rng = 0;
    end else begin
      if (x < 0) begin
        z = (y >= 0) ? PI_A : -PI_A;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        if (y < 0) begin
          t = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
        end else begin
          t = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
        end
        x = t;
      end
      brg = round_shr(z, 14);
      ux = x;
      rng = longint'(((ux >> 20) * INV_GAIN_26 + 64'd536870912) >> 30);
    end
  endtask

  task automatic predict_command(input in_word_t w, output out_word_t o);
    longint rate, ax, ay, c, s, wx, wy, brg, rng, err, turn, speed;
    o = '0;
    if (landed) begin
      o.arrived = 1'b1;
    end else begin
      if (begun) begin
        rate = clamp32(sext32(w.gyro_z) - GYRO_BIAS);
        ax = clamp32(sext32(w.accel_x) - ACCX_BIAS);
        ay = clamp32(sext32(w.accel_y) - ACCY_BIAS);
        hdg = clamp32(hdg + fxmul(rate, dt));
        rotate_unit(hdg, c, s);
        wx = clamp32(fxmul(ax, c) - fxmul(ay, s));
        wy = clamp32(fxmul(ax, s) + fxmul(ay, c));
        vx = clamp32(vx + fxmul(wx, dt));
        vy = clamp32(vy + fxmul(wy, dt));
        px = clamp32(px + fxmul(vx, dt));
        py = clamp32(py + fxmul(vy, dt));
      end
      begun = 1'b1;
      bearing_range(goal_x_r - px, goal_y_r - py, brg, rng);
      err = clamp32(hdg - brg);
      err_sum = clamp32(err_sum + err);
      turn = clamp32(fxmul(ki, err_sum) + fxmul(kd, err - err_prev) - fxmul(kp, err));
      err_prev = err;
      if (rng > 64'sd2147483647) rng = 64'sd2147483647;
      speed = clamp32(fxmul(kdist, rng));
      rotate_unit(hdg, c, s);
      vx = clamp32(fxmul(speed, c));
      vy = clamp32(fxmul(speed, s));
      if (rng < radius) begin
        vx = 0; vy = 0; turn = 0;
        landed = 1'b1;
      end
      o.turn_rate = turn[31:0];
      o.cmd_vel_x = vx[31:0];
      o.cmd_vel_y = vy[31:0];
      o.arrived = landed;
    end
  endtask

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("cycle %0d: %s got %0d want %0d", cycles, what, got, want);
    mismatches++;
  endtask

  // result check, register shadowing and prediction, all on the rising edge
  always @(posedge clk) begin
    out_word_t want, pred;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (cmd_q.size() == 0) begin
          flag_mismatch("unexpected word, turn_rate", out_word.turn_rate, 0);
        end else begin
          want = cmd_q.pop_front();
          if (out_word.turn_rate !== want.turn_rate)
            flag_mismatch("turn_rate", out_word.turn_rate, want.turn_rate);
          if (out_word.cmd_vel_x !== want.cmd_vel_x)
            flag_mismatch("cmd_vel_x", out_word.cmd_vel_x, want.cmd_vel_x);
          if (out_word.cmd_vel_y !== want.cmd_vel_y)
            flag_mismatch("cmd_vel_y", out_word.cmd_vel_y, want.cmd_vel_y);
          if (out_word.arrived !== want.arrived)
            flag_mismatch("arrived", out_word.arrived, want.arrived);
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_GOAL_X:        goal_x_r = sext32(cfg_wdata);
          CFG_GOAL_Y:        goal_y_r = sext32(cfg_wdata);
          CFG_GAIN_P:        kp = longint'(cfg_wdata[30:0]);
          CFG_GAIN_I:        ki = longint'(cfg_wdata[30:0]);
          CFG_GAIN_D:        kd = longint'(cfg_wdata[30:0]);
          CFG_GAIN_DIST:     kdist = longint'(cfg_wdata[30:0]);
          CFG_SAMPLE_PERIOD: dt = longint'(cfg_wdata[30:0]);
          CFG_STOP_RADIUS:   radius = longint'(cfg_wdata[30:0]);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_command(in_word, pred);
        cmd_q.push_back(pred);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    int r;
    if (hold_req) begin
      stall_left = 3000;
      hold_req = 1'b0;
    end
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (quiet || r < 70) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 50);
    end
  end

  // called and returns right after the accepting rising edge
  task automatic send_sample(input in_word_t w);
    int r, gap;
    @(negedge clk);
    r = $urandom_range(0, 99);
    gap = (quiet || r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= 3'(cfg_idx_t'(i));
      cfg_wdata <= next_regs[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] signed_span(int span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  function automatic in_word_t motion_sample();
    in_word_t w;
    w.gyro_z  = ($urandom_range(0, 9) == 0) ? $urandom : signed_span(2 * 65536);
    w.accel_x = ($urandom_range(0, 9) == 0) ? $urandom : signed_span(20 * 65536);
    w.accel_y = ($urandom_range(0, 9) == 0) ? $urandom : signed_span(20 * 65536);
    return w;
  endfunction

  // unsigned registers get a random top bit, which the block drops
  task automatic pick_settings();
    next_regs[CFG_GOAL_X]        = signed_span(40 * 65536);
    next_regs[CFG_GOAL_Y]        = signed_span(40 * 65536);
    next_regs[CFG_GAIN_P]        = 32'($urandom_range(0, 20 * 65536));
    next_regs[CFG_GAIN_I]        = 32'($urandom_range(0, 65536));
    next_regs[CFG_GAIN_D]        = 32'($urandom_range(0, 2 * 65536));
    next_regs[CFG_GAIN_DIST]     = 32'($urandom_range(0, 65536));
    next_regs[CFG_SAMPLE_PERIOD] = 32'($urandom_range(328, 6554));
    next_regs[CFG_STOP_RADIUS]   = 32'h0;
    for (int i = 2; i < 8; i++) next_regs[i][31] = $urandom_range(0, 1);
  endtask

  // first word after reset ignores its fields; default registers
  task automatic test_first_sample();
    send_sample('{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF});
    send_sample('{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000});
    send_sample('{32'sd0, 32'sd0, 32'sd0});
    drain();
  endtask

  task automatic test_random_flight();
    for (int ph = 0; ph < 6; ph++) begin
      pick_settings();
      write_regs();
      quiet = (ph == 2);
      for (int n = 0; n < 105; n++) send_sample(motion_sample());
      drain();
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    hold_req = 1'b1;
    for (int n = 0; n < 6; n++) send_sample(motion_sample());
    drain();
  endtask

  task automatic test_extremes();
    // frozen pose with the goal on it: zero offset, zero bearing
    next_regs[CFG_SAMPLE_PERIOD] = 32'h0;
    next_regs[CFG_STOP_RADIUS] = 32'h0;
    next_regs[CFG_GOAL_X] = px[31:0];
    next_regs[CFG_GOAL_Y] = py[31:0];
    write_regs();
    send_sample('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000});
    send_sample(motion_sample());
    drain();
    // far goal: distance saturates; all gains and time step at full scale
    next_regs[CFG_GOAL_X] = 32'h80000000;
    next_regs[CFG_GOAL_Y] = 32'h80000000;
    for (int i = 2; i < 7; i++) next_regs[i] = 32'hFFFFFFFF;
    write_regs();
    send_sample('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
    send_sample('{32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000});
    send_sample('{32'sh80000000, 32'sh80000000, 32'sh80000000});
    send_sample('{32'sh80000000, 32'sh00000000, 32'sh7FFFFFFF});
    drain();
    next_regs[CFG_GOAL_X] = 32'h7FFFFFFF;
    next_regs[CFG_GOAL_Y] = 32'h00000000;
    for (int i = 2; i < 7; i++) next_regs[i] = 32'h0;
    write_regs();
    for (int n = 0; n < 4; n++) send_sample(motion_sample());
    drain();
  endtask

  // widest radius latches arrival; then zeros no matter what
  task automatic test_arrival();
    pick_settings();
    next_regs[CFG_STOP_RADIUS] = 32'hFFFFFFFF;
    write_regs();
    for (int n = 0; n < 6; n++) send_sample(motion_sample());
    drain();
    pick_settings();
    write_regs();
    for (int n = 0; n < 6; n++) send_sample(motion_sample());
    drain();
  endtask

  initial begin
    build_atan();
    goal_x_r = 10 * ONE; goal_y_r = 10 * ONE; kp = 10 * ONE;
    ki = 6554; kd = 6554; kdist = 6554; dt = 1311; radius = ONE;
    hdg = HDG_RESET; px = 0; py = 0; vx = 0; vy = 0; err_sum = 0; err_prev = 0;
    begun = 1'b0; landed = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_first_sample();
    test_random_flight();
    test_backpressure();
    test_extremes();
    test_arrival();
    repeat (700) @(posedge clk);
    if (cmd_q.size() != 0) flag_mismatch("words never returned", cmd_q.size(), 0);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/idrg_pkg.sv
rtl/core/idrg_smul.sv
rtl/core/imu_dead_reckon_pid_guidance.sv
rtl/core/idrg_chk.sv
tb/imu_dead_reckon_pid_guidance_tb.sv
